/* rtl/salct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salct_pkg
// Shared constants and types of the set-associative LRU cache tag block.
// ----------------------------------------------------------------------------
package salct_pkg;

  // Fixed field widths of the access and result beats
  localparam int ADDR_W     = 32;
  localparam int WAY_W      = 4;
  localparam int CNT_W      = 32;
  localparam int LINE_SHIFT = 5;    // 32-byte lines

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_NO_ALLOC = 1'd1;
  localparam logic [2:0]           WAYS_LOG2_RST      = 3'd1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Per-access control into the set update logic
  typedef struct packed {
    logic is_store;
    logic no_alloc;
  } acc_ctl_t;

  // Outcome of the set update
  typedef struct packed {
    logic hit;
    logic wr_en;
  } acc_stat_t;

endpackage

/* rtl/salct_row_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salct_row_ram
// Single-clock row memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module salct_row_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 432,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first; same-row collisions are forwarded by the user
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/salct_set_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salct_set_update
// Tag compare, LRU promotion and victim fill for one set inside a row.
// ----------------------------------------------------------------------------
module salct_set_update #(
  parameter int LOG_W = 4,
  parameter int TAG_W = 22
) (
  input  logic [LOG_W-1:0]           wmask,    // ways - 1
  input  logic [LOG_W-1:0]           off,      // first lane of the set
  input  logic [TAG_W-1:0]           tag,
  input  salct_pkg::acc_ctl_t        ctl,
  input  logic [(1<<LOG_W)*TAG_W-1:0] tags_in,
  input  logic [(1<<LOG_W)-1:0]       vld_in,
  input  logic [(1<<LOG_W)*LOG_W-1:0] lru_in,
  output logic [(1<<LOG_W)*TAG_W-1:0] tags_out,
  output logic [(1<<LOG_W)-1:0]       vld_out,
  output logic [(1<<LOG_W)*LOG_W-1:0] lru_out,
  output logic [LOG_W-1:0]           way,
  output salct_pkg::acc_stat_t       stat
);

  localparam int W = 1 << LOG_W;

  logic [LOG_W-1:0] lru_a  [W];
  logic [TAG_W-1:0] tag_a  [W];
  logic [W-1:0]     in_set;
  logic [LOG_W-1:0] pidx   [W];
  logic             hit;
  logic [LOG_W-1:0] hit_way;
  logic [LOG_W-1:0] pos;
  logic [LOG_W-1:0] victim;
  logic [LOG_W-1:0] sel_way;
  logic             do_upd;

  always_comb begin
    for (int j = 0; j < W; j++) begin
      lru_a[j]  = lru_in[j*LOG_W +: LOG_W];
      tag_a[j]  = tags_in[j*TAG_W +: TAG_W];
      pidx[j]   = LOG_W'(j) & wmask;
      in_set[j] = ((LOG_W'(j) & ~wmask) == off);
    end
  end

  // last matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int j = 0; j < W; j++) begin
      if (in_set[j] && vld_in[j] && (tag_a[j] == tag)) begin
        hit     = 1'b1;
        hit_way = pidx[j];
      end
    end
  end

  assign victim  = lru_a[off | wmask] & wmask;
  assign do_upd  = hit || !(ctl.is_store && ctl.no_alloc);
  assign sel_way = hit ? hit_way : victim;

  // LRU position of the hit way; a miss promotes from the tail
  always_comb begin
    pos = wmask;
    if (hit) begin
      for (int j = 0; j < W; j++) begin
        if (in_set[j] && ((lru_a[j] & wmask) == hit_way)) begin
          pos = pidx[j];
        end
      end
    end
  end

  always_comb begin
    int prv;
    for (int j = 0; j < W; j++) begin
      prv = (j == 0) ? 0 : j - 1;
      lru_out[j*LOG_W +: LOG_W]  = lru_a[j];
      tags_out[j*TAG_W +: TAG_W] = tag_a[j];
      vld_out[j]                 = vld_in[j];
      if (in_set[j] && do_upd) begin
        if (pidx[j] == '0) begin
          lru_out[j*LOG_W +: LOG_W] = sel_way;
        end else if (pidx[j] <= pos) begin
          lru_out[j*LOG_W +: LOG_W] = lru_a[prv];
        end
        if (!hit && (pidx[j] == victim)) begin
          tags_out[j*TAG_W +: TAG_W] = tag;
          vld_out[j]                 = 1'b1;
        end
      end
    end
  end

  assign way        = do_upd ? sel_way : '0;
  assign stat.hit   = hit;
  assign stat.wr_en = do_upd;

endmodule

/* rtl/set_assoc_lru_cache_tags.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag and LRU replacement tracking of a set-associative cache, 1..MAX_WAYS
// ways, write-no-allocate option, saturating hit counter.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// in_      in   in_valid/in_stall   in_is_store, in_address
// out_     out  out_valid/out_stall out_hit, out_way, out_hit_count
// cfg_     in   cfg_we              cfg_index, cfg_data
//
// Input beat to result: row RAM read, then compare/update with write-back.
// One beat per cycle sustained unless the output stalls; a back-to-back
// access to the same row is served from the write-back data, not the RAM.
// Reset clears per-row valid flops at once, no clearing pass; a ways_log2
// write does the same. A stalled result holds the update stage, and the
// input stalls only while that stage cannot move.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
  parameter int LINES     = 512,
  parameter int MAX_WAYS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_is_store,
  input  logic [salct_pkg::ADDR_W-1:0]     in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [salct_pkg::WAY_W-1:0]      out_way,
  output logic [salct_pkg::CNT_W-1:0]      out_hit_count,
  input  logic                             cfg_we,
  input  logic [salct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salct_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LOG_LINES = $clog2(LINES);
  localparam int LOG_MW    = $clog2(MAX_WAYS + 1) - 1;
  localparam int LOG_W     = (LOG_MW < LOG_LINES) ? LOG_MW : LOG_LINES;
  localparam int W         = 1 << LOG_W;
  localparam int ROWS      = LINES >> LOG_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AU        = (ADDR_BITS < salct_pkg::ADDR_W) ? ADDR_BITS : salct_pkg::ADDR_W;
  localparam int LW        = AU - salct_pkg::LINE_SHIFT;
  localparam int TAG_RAW   = LW - (LOG_LINES - LOG_W);
  localparam int TAG_W     = (TAG_RAW > 1) ? TAG_RAW : 1;
  localparam int SH_W      = $clog2(LOG_LINES + 1);
  localparam int RW        = W * (TAG_W + 1 + LOG_W);

  // configuration
  logic [2:0]       ways_log2_r;
  logic             no_alloc_r;
  logic [2:0]       k_eff;
  logic [LOG_W-1:0] wmask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_log2_r <= salct_pkg::WAYS_LOG2_RST;
      no_alloc_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        salct_pkg::CFG_WAYS_LOG2:      ways_log2_r <= cfg_data;
        salct_pkg::CFG_WRITE_NO_ALLOC: no_alloc_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign k_eff = (ways_log2_r > 3'(LOG_W)) ? 3'(LOG_W) : ways_log2_r;
  assign wmask = ~({LOG_W{1'b1}} << k_eff);

  // address split at accept
  logic                  accept;
  logic                  advance;
  logic [LW-1:0]         line;
  logic [LW+LOG_LINES-1:0] line_wide;
  logic [LOG_LINES-1:0]  line_lo;
  logic [LOG_LINES-1:0]  base;
  logic [SH_W-1:0]       sh;
  logic [LW-1:0]         tag_sh;
  logic [LW+TAG_W-1:0]   tag_wide;
  logic [TAG_W-1:0]      acc_tag;
  logic [ROW_W-1:0]      acc_row;

  assign line      = in_address[AU-1:salct_pkg::LINE_SHIFT];
  assign line_wide = {{LOG_LINES{1'b0}}, line};
  assign line_lo   = line_wide[LOG_LINES-1:0];
  assign base      = line_lo << k_eff;
  assign sh        = SH_W'(LOG_LINES) - SH_W'(k_eff);
  assign tag_sh    = line >> sh;
  assign tag_wide  = {{TAG_W{1'b0}}, tag_sh};
  assign acc_tag   = tag_wide[TAG_W-1:0];
  assign acc_row   = ROW_W'(base >> LOG_W);

  // update stage
  logic             s1_valid_r;
  logic             s1_store_r;
  logic [TAG_W-1:0] s1_tag_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [LOG_W-1:0] s1_off_r;
  logic             fwd_r;
  logic [RW-1:0]    fwd_data_r;
  logic [ROWS-1:0]  rv_r;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [salct_pkg::WAY_W-1:0] out_way_r;
  logic [salct_pkg::CNT_W-1:0] out_hit_count_r;
  logic [salct_pkg::CNT_W-1:0] cnt_r;
  logic [salct_pkg::CNT_W-1:0] cnt_nxt;

  logic [RW-1:0]          rd_data;
  logic [RW-1:0]          cur;
  logic                   row_ok;
  logic [W*TAG_W-1:0]     tags_cur;
  logic [W-1:0]           vld_cur;
  logic [W*LOG_W-1:0]     lru_cur;
  logic [W*TAG_W-1:0]     tags_new;
  logic [W-1:0]           vld_new;
  logic [W*LOG_W-1:0]     lru_new;
  logic [LOG_W-1:0]       upd_way;
  salct_pkg::acc_ctl_t    ctl;
  salct_pkg::acc_stat_t   stat;
  logic                   mem_we;
  logic [RW-1:0]          wdata;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  salct_row_ram #(
    .DEPTH (ROWS),
    .WIDTH (RW),
    .AW    (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_row_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (acc_row),
    .rdata (rd_data)
  );

  assign cur    = fwd_r ? fwd_data_r : rd_data;
  assign row_ok = rv_r[s1_row_r];

  // a row never written reads as the reset view: nothing valid, identity LRU
  always_comb begin
    tags_cur = cur[W*TAG_W-1:0];
    vld_cur  = row_ok ? cur[W*TAG_W +: W] : '0;
    for (int j = 0; j < W; j++) begin
      lru_cur[j*LOG_W +: LOG_W] = row_ok ? cur[W*TAG_W + W + j*LOG_W +: LOG_W]
                                         : (LOG_W'(j) & wmask);
    end
  end

  assign ctl.is_store = s1_store_r;
  assign ctl.no_alloc = no_alloc_r;

  salct_set_update #(
    .LOG_W (LOG_W),
    .TAG_W (TAG_W)
  ) u_upd (
    .wmask    (wmask),
    .off      (s1_off_r),
    .tag      (s1_tag_r),
    .ctl      (ctl),
    .tags_in  (tags_cur),
    .vld_in   (vld_cur),
    .lru_in   (lru_cur),
    .tags_out (tags_new),
    .vld_out  (vld_new),
    .lru_out  (lru_new),
    .way      (upd_way),
    .stat     (stat)
  );

  assign mem_we  = advance && stat.wr_en;
  assign wdata   = {lru_new, vld_new, tags_new};
  assign cnt_nxt = (stat.hit && (cnt_r != salct_pkg::CNT_MAX)) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      rv_r        <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= mem_we && (s1_row_r == acc_row);
      end else if (advance) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
      if (cfg_we && (cfg_index == salct_pkg::CFG_WAYS_LOG2)) begin
        rv_r <= '0;
      end else if (mem_we) begin
        rv_r[s1_row_r] <= 1'b1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_store_r <= in_is_store;
      s1_tag_r   <= acc_tag;
      s1_row_r   <= acc_row;
      s1_off_r   <= base[LOG_W-1:0];
      fwd_data_r <= wdata;
    end
    if (advance) begin
      out_hit_r       <= stat.hit;
      out_way_r       <= salct_pkg::WAY_W'(upd_way);
      out_hit_count_r <= cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_way       = out_way_r;
  assign out_hit_count = out_hit_count_r;

  // write-back only from a moving update stage
  assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> advance)
    else $error("row write without update stage advancing");

  // forwarded row only stands behind a live access
  assert property (@(posedge clk) disable iff (!rst_n) fwd_r |-> s1_valid_r)
    else $error("forward flag set with empty update stage");

  // a hit always shows a nonzero count
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stat.hit) |=> (out_valid && out_hit && (out_hit_count != '0)))
    else $error("hit result lost or counted as zero");

  // geometry change flushes every row
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == salct_pkg::CFG_WAYS_LOG2)) |=> (rv_r == '0))
    else $error("row valid bits survived a geometry change");

endmodule
